// ----- hdl/phc_pkg.sv -----
// Package for the PID heater controller: number formats, register map and reset values.
// Used by pid_heater_control_top, phc_checker and the testbench; depends on nothing else.
package phc_pkg;

  // Sample format: signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS.
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  // Gains are unsigned Q8.8; limits are the positive half of the data range.
  localparam int GAIN_BITS = 16;
  localparam int LIM_BITS  = DATA_WIDTH - 1;

  // Derived datapath widths.
  localparam int ERR_W  = DATA_WIDTH + 1;             // target - measured
  localparam int ACC_W  = ERR_W + 1;                  // error_sum + err before clamp
  localparam int DIFF_W = ERR_W + 1;                  // err - previous_error
  localparam int PROD_W = GAIN_BITS + 1 + DIFF_W;     // widest gain product
  localparam int SUM_W  = PROD_W - FRAC_BITS + 2;     // four scaled terms added exactly
  localparam int DRV_W  = DATA_WIDTH + 1;             // previous drive +- rate limit
  localparam int FF3_W  = DATA_WIDTH + 2;             // 3 * feed_forward

  // Register file and APB port.
  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int PDATA_W   = 32;

  localparam logic [REG_IDX_W-1:0] REG_GAIN_P         = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I         = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D         = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_OUTPUT_LIMIT   = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_RATE_LIMIT     = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_DEADBAND       = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_BAND  = REG_IDX_W'(7);

  // Reset values are the auto-tune defaults in Q8.8.
  localparam logic [GAIN_BITS-1:0] GAIN_P_RST         = GAIN_BITS'(922);
  localparam logic [GAIN_BITS-1:0] GAIN_I_RST         = GAIN_BITS'(461);
  localparam logic [GAIN_BITS-1:0] GAIN_D_RST         = GAIN_BITS'(461);
  localparam logic [LIM_BITS-1:0]  INTEGRAL_LIMIT_RST = LIM_BITS'(5120);
  localparam logic [LIM_BITS-1:0]  OUTPUT_LIMIT_RST   = LIM_BITS'(12800);
  localparam logic [LIM_BITS-1:0]  RATE_LIMIT_RST     = LIM_BITS'(512);
  localparam logic [LIM_BITS-1:0]  DEADBAND_RST       = LIM_BITS'(128);
  localparam logic [LIM_BITS-1:0]  INTEGRAL_BAND_RST  = LIM_BITS'(26);

endpackage

// ----- hdl/pid_heater_control_top.sv -----
// PID heater controller with integral anti-windup, output clamp and drive rate limit.
// Depends on phc_pkg for formats, register map and reset values.
//
//   channel   direction  handshake                 payload
//   -------   ---------  ------------------------  -----------------------------------------
//   sample    in         in_valid_i / in_ready_o   target_temp_i, measured_temp_i,
//                                                  feed_forward_i
//   result    out        out_valid_o / out_ready_i heater_on_o, drive_level_o, pid_level_o,
//                                                  temp_error_o
//   config    in         APB psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// A request sits in the input register while all the arithmetic is done combinationally,
// and its result moves into the result register once that register is free or emptied.
// One request is accepted per cycle while the result side takes every result; when a result
// waits, the input register still takes one more request and then holds in_ready_o low.
// Reset clears the controller state (integral, previous error, previous drive) and
// loads the auto-tune gains and default limits into the configuration registers.
module pid_heater_control_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Sample channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [phc_pkg::DATA_WIDTH-1:0] target_temp_i,
  input  logic signed [phc_pkg::DATA_WIDTH-1:0] measured_temp_i,
  input  logic signed [phc_pkg::DATA_WIDTH-1:0] feed_forward_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 heater_on_o,
  output logic signed [phc_pkg::DATA_WIDTH-1:0] drive_level_o,
  output logic signed [phc_pkg::DATA_WIDTH-1:0] pid_level_o,
  output logic signed [phc_pkg::ERR_W-1:0]      temp_error_o,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [phc_pkg::ADDR_W-1:0]           paddr,
  input  logic [phc_pkg::PDATA_W-1:0]          pwdata,
  output logic [phc_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [phc_pkg::GAIN_BITS-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [phc_pkg::LIM_BITS-1:0]  integral_limit_q, output_limit_q, rate_limit_q;
  logic [phc_pkg::LIM_BITS-1:0]  deadband_q, integral_band_q;

  logic                          cfg_wr;
  logic [phc_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  // Registers sit on word boundaries, so the low two address bits are ignored.
  assign cfg_idx = paddr[phc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q         <= phc_pkg::GAIN_P_RST;
      gain_i_q         <= phc_pkg::GAIN_I_RST;
      gain_d_q         <= phc_pkg::GAIN_D_RST;
      integral_limit_q <= phc_pkg::INTEGRAL_LIMIT_RST;
      output_limit_q   <= phc_pkg::OUTPUT_LIMIT_RST;
      rate_limit_q     <= phc_pkg::RATE_LIMIT_RST;
      deadband_q       <= phc_pkg::DEADBAND_RST;
      integral_band_q  <= phc_pkg::INTEGRAL_BAND_RST;
    end else if (cfg_wr) begin
      // Data bits above a register's width are dropped.
      case (cfg_idx)
        phc_pkg::REG_GAIN_P:         gain_p_q         <= pwdata[phc_pkg::GAIN_BITS-1:0];
        phc_pkg::REG_GAIN_I:         gain_i_q         <= pwdata[phc_pkg::GAIN_BITS-1:0];
        phc_pkg::REG_GAIN_D:         gain_d_q         <= pwdata[phc_pkg::GAIN_BITS-1:0];
        phc_pkg::REG_INTEGRAL_LIMIT: integral_limit_q <= pwdata[phc_pkg::LIM_BITS-1:0];
        phc_pkg::REG_OUTPUT_LIMIT:   output_limit_q   <= pwdata[phc_pkg::LIM_BITS-1:0];
        phc_pkg::REG_RATE_LIMIT:     rate_limit_q     <= pwdata[phc_pkg::LIM_BITS-1:0];
        phc_pkg::REG_DEADBAND:       deadband_q       <= pwdata[phc_pkg::LIM_BITS-1:0];
        phc_pkg::REG_INTEGRAL_BAND:  integral_band_q  <= pwdata[phc_pkg::LIM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read data is driven straight from the addressed register.
  always_comb begin
    case (cfg_idx)
      phc_pkg::REG_GAIN_P:         prdata = phc_pkg::PDATA_W'(gain_p_q);
      phc_pkg::REG_GAIN_I:         prdata = phc_pkg::PDATA_W'(gain_i_q);
      phc_pkg::REG_GAIN_D:         prdata = phc_pkg::PDATA_W'(gain_d_q);
      phc_pkg::REG_INTEGRAL_LIMIT: prdata = phc_pkg::PDATA_W'(integral_limit_q);
      phc_pkg::REG_OUTPUT_LIMIT:   prdata = phc_pkg::PDATA_W'(output_limit_q);
      phc_pkg::REG_RATE_LIMIT:     prdata = phc_pkg::PDATA_W'(rate_limit_q);
      phc_pkg::REG_DEADBAND:       prdata = phc_pkg::PDATA_W'(deadband_q);
      phc_pkg::REG_INTEGRAL_BAND:  prdata = phc_pkg::PDATA_W'(integral_band_q);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake. The input register holds one accepted request; it moves into the
  // result register whenever that register is empty or being emptied, and the
  // input register takes a new request in the same cycle.
  // ---------------------------------------------------------------------------
  logic in_vld_q, in_vld_d;
  logic out_vld_q, out_vld_d;
  logic in_take, advance;

  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;
  assign in_take    = in_valid_i & in_ready_o;
  assign in_vld_d   = in_take | (in_vld_q & ~advance);
  assign out_vld_d  = advance | (out_vld_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  logic signed [phc_pkg::DATA_WIDTH-1:0] target_q, measured_q, ff_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      target_q   <= target_temp_i;
      measured_q <= measured_temp_i;
      ff_q       <= feed_forward_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state.
  // ---------------------------------------------------------------------------
  logic signed [phc_pkg::DATA_WIDTH-1:0] esum_q, esum_d;
  logic signed [phc_pkg::ERR_W-1:0]      prev_err_q;
  logic signed [phc_pkg::DATA_WIDTH-1:0] prev_drive_q;

  // ---------------------------------------------------------------------------
  // Datapath: error, integral with anti-windup, PID terms, clamps, rate limit.
  // ---------------------------------------------------------------------------
  logic signed [phc_pkg::ERR_W-1:0]      err;
  logic        [phc_pkg::ERR_W-1:0]      err_mag;
  logic                                  integrate;
  logic signed [phc_pkg::ACC_W-1:0]      acc, ilim_pos, ilim_neg, acc_clamped;
  logic signed [phc_pkg::GAIN_BITS:0]    gp_s, gi_s, gd_s;
  logic signed [phc_pkg::DIFF_W-1:0]     err_diff;
  logic signed [phc_pkg::PROD_W-1:0]     p_prod, i_prod, d_prod;
  logic signed [phc_pkg::FF3_W-1:0]      ff_x, ff3;
  logic signed [phc_pkg::SUM_W-1:0]      p_term, i_term, d_term, f_term, pid_sum;
  logic signed [phc_pkg::SUM_W-1:0]      olim_pos, pid_full;
  logic signed [phc_pkg::DATA_WIDTH-1:0] pid_d;
  logic signed [phc_pkg::DRV_W-1:0]      pid_x, prev_x, rlim_s, drv_lo, drv_hi, drive_x;
  logic signed [phc_pkg::DATA_WIDTH-1:0] drive_d;
  logic                                  heat_d;

  always_comb begin
    err     = phc_pkg::ERR_W'(target_q) - phc_pkg::ERR_W'(measured_q);
    err_mag = err[phc_pkg::ERR_W-1] ? phc_pkg::ERR_W'(-err) : phc_pkg::ERR_W'(err);

    // The integral runs only while the error is outside the band, else it drops to zero.
    integrate   = err_mag > phc_pkg::ERR_W'(integral_band_q);
    acc         = phc_pkg::ACC_W'(esum_q) + phc_pkg::ACC_W'(err);
    ilim_pos    = $signed(phc_pkg::ACC_W'(integral_limit_q));
    ilim_neg    = -ilim_pos;
    if (acc < ilim_neg) begin
      acc_clamped = ilim_neg;
    end else if (acc > ilim_pos) begin
      acc_clamped = ilim_pos;
    end else begin
      acc_clamped = acc;
    end
    esum_d = integrate ? phc_pkg::DATA_WIDTH'(acc_clamped) : '0;

    // Gains are unsigned; a zero sign bit makes them signed operands.
    gp_s     = $signed({1'b0, gain_p_q});
    gi_s     = $signed({1'b0, gain_i_q});
    gd_s     = $signed({1'b0, gain_d_q});
    err_diff = phc_pkg::DIFF_W'(err) - phc_pkg::DIFF_W'(prev_err_q);

    p_prod = gp_s * err;
    i_prod = gi_s * esum_d;
    d_prod = gd_s * err_diff;

    p_term = phc_pkg::SUM_W'(p_prod >>> phc_pkg::FRAC_BITS);
    i_term = phc_pkg::SUM_W'(i_prod >>> phc_pkg::FRAC_BITS);
    d_term = phc_pkg::SUM_W'(d_prod >>> phc_pkg::FRAC_BITS);

    // 1.5 * feed_forward in Q format reduces to floor(3 * ff / 2).
    ff_x   = phc_pkg::FF3_W'(ff_q);
    ff3    = ff_x + (ff_x <<< 1);
    f_term = phc_pkg::SUM_W'(ff3 >>> 1);

    pid_sum  = p_term + i_term + d_term + f_term;
    olim_pos = $signed(phc_pkg::SUM_W'(output_limit_q));
    if (pid_sum < -olim_pos) begin
      pid_full = -olim_pos;
    end else if (pid_sum > olim_pos) begin
      pid_full = olim_pos;
    end else begin
      pid_full = pid_sum;
    end
    pid_d = phc_pkg::DATA_WIDTH'(pid_full);

    // The drive moves toward the PID value by at most rate_limit per sample, so it
    // always lies between the previous drive and the PID value.
    pid_x  = phc_pkg::DRV_W'(pid_d);
    prev_x = phc_pkg::DRV_W'(prev_drive_q);
    rlim_s = $signed(phc_pkg::DRV_W'(rate_limit_q));
    drv_lo = prev_x - rlim_s;
    drv_hi = prev_x + rlim_s;
    if (pid_x < drv_lo) begin
      drive_x = drv_lo;
    end else if (pid_x > drv_hi) begin
      drive_x = drv_hi;
    end else begin
      drive_x = pid_x;
    end
    drive_d = phc_pkg::DATA_WIDTH'(drive_x);

    // Heat only for a positive drive and an error at or above the deadband.
    heat_d = (err_mag >= phc_pkg::ERR_W'(deadband_q))
           & ~drive_d[phc_pkg::DATA_WIDTH-1] & (|drive_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q       <= '0;
      prev_err_q   <= '0;
      prev_drive_q <= '0;
    end else if (advance) begin
      esum_q       <= esum_d;
      prev_err_q   <= err;
      prev_drive_q <= drive_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic                                  heat_q;
  logic signed [phc_pkg::DATA_WIDTH-1:0] drive_q, pid_q;
  logic signed [phc_pkg::ERR_W-1:0]      err_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      heat_q  <= heat_d;
      drive_q <= drive_d;
      pid_q   <= pid_d;
      err_q   <= err;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign heater_on_o   = heat_q;
  assign drive_level_o = drive_q;
  assign pid_level_o   = pid_q;
  assign temp_error_o  = err_q;

`ifndef NO_ASSERTIONS
  // A new drive never overshoots: it lies between the previous drive and the PID value.
  a_drive_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> ((drive_d >= pid_d && drive_d <= prev_drive_q) ||
                 (drive_d <= pid_d && drive_d >= prev_drive_q)))
    else $error("drive left the span between previous drive and PID value");

  // The PID value respects the output clamp.
  a_pid_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> (phc_pkg::SUM_W'(pid_d) <= olim_pos && phc_pkg::SUM_W'(pid_d) >= -olim_pos))
    else $error("PID value outside the output limit");

  // A shown result with the heater on always carries a positive drive.
  a_heat_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && heat_q) |-> (drive_q > 0))
    else $error("heater on with a drive that is not positive");

  // A request in the input register reaches an empty result register in the next cycle.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_vld_q) |=> out_vld_q)
    else $error("request stalled although the result register was free");
`endif

endmodule

// ----- test/phc_checker.sv -----
`timescale 1ns / 1ps
// Checker for the PID heater controller: follows the APB writes, predicts one result per
// accepted request and compares it with the results that the controller hands out.
// Depends on phc_pkg for widths, the register map and the register reset values.
module phc_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_o,
  input  logic signed [phc_pkg::DATA_WIDTH-1:0] target_temp_i,
  input  logic signed [phc_pkg::DATA_WIDTH-1:0] measured_temp_i,
  input  logic signed [phc_pkg::DATA_WIDTH-1:0] feed_forward_i,
  input  logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  input  logic                                  heater_on_o,
  input  logic signed [phc_pkg::DATA_WIDTH-1:0] drive_level_o,
  input  logic signed [phc_pkg::DATA_WIDTH-1:0] pid_level_o,
  input  logic signed [phc_pkg::ERR_W-1:0]      temp_error_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [phc_pkg::ADDR_W-1:0]            paddr,
  input  logic [phc_pkg::PDATA_W-1:0]           pwdata,
  input  logic                                  pready,
  output int                                    errors_o,
  output int                                    pending_o
);
  import phc_pkg::*;

  typedef struct packed {
    logic                         heater_on;
    logic signed [DATA_WIDTH-1:0] drive_level;
    logic signed [DATA_WIDTH-1:0] pid_level;
    logic signed [ERR_W-1:0]      temp_error;
  } heater_result_t;

  heater_result_t expected_results[$];
  int             mismatch_count = 0;

  // Shadow copy of the configuration registers.
  logic [GAIN_BITS-1:0] gain_p, gain_i, gain_d;
  logic [LIM_BITS-1:0]  integral_limit, output_limit, rate_limit, deadband, integral_band;

  // Controller state as the block keeps it.
  logic signed [DATA_WIDTH-1:0] error_sum;
  logic signed [ERR_W-1:0]      last_error;
  logic signed [DATA_WIDTH-1:0] last_drive;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // One control step: updates the shadow state and returns the result it causes.
  function automatic heater_result_t predict_heater_step(
    input logic signed [DATA_WIDTH-1:0] tgt,
    input logic signed [DATA_WIDTH-1:0] meas,
    input logic signed [DATA_WIDTH-1:0] ff
  );
    heater_result_t res;
    longint err, acc, p_term, i_term, d_term, f_term, pid, drv, olim, rlim;
    err = longint'(tgt) - longint'(meas);
    if (magnitude(err) > longint'(integral_band))
      acc = clip(longint'(error_sum) + err, -longint'(integral_limit),
                 longint'(integral_limit));
    else
      acc = 0;
    p_term = (longint'(gain_p) * err) >>> FRAC_BITS;
    i_term = (longint'(gain_i) * acc) >>> FRAC_BITS;
    d_term = (longint'(gain_d) * (err - longint'(last_error))) >>> FRAC_BITS;
    f_term = (longint'(ff) * (longint'(3) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    olim   = longint'(output_limit);
    rlim   = longint'(rate_limit);
    pid    = clip(p_term + i_term + d_term + f_term, -olim, olim);
    drv    = clip(pid, longint'(last_drive) - rlim, longint'(last_drive) + rlim);
    res.heater_on   = (magnitude(err) >= longint'(deadband)) && (drv > 0);
    res.drive_level = DATA_WIDTH'(drv);
    res.pid_level   = DATA_WIDTH'(pid);
    res.temp_error  = ERR_W'(err);
    error_sum  = DATA_WIDTH'(acc);
    last_error = ERR_W'(err);
    last_drive = DATA_WIDTH'(drv);
    return res;
  endfunction

  task automatic note_mismatch(input string field, input longint want, input longint got);
    mismatch_count++;
    $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    heater_result_t want;
    logic [REG_IDX_W-1:0] idx;
    if (!rst_ni) begin
      gain_p         = GAIN_P_RST;
      gain_i         = GAIN_I_RST;
      gain_d         = GAIN_D_RST;
      integral_limit = INTEGRAL_LIMIT_RST;
      output_limit   = OUTPUT_LIMIT_RST;
      rate_limit     = RATE_LIMIT_RST;
      deadband       = DEADBAND_RST;
      integral_band  = INTEGRAL_BAND_RST;
      error_sum      = '0;
      last_error     = '0;
      last_drive     = '0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = paddr[ADDR_W-1:2];
        case (idx)
          REG_GAIN_P:         gain_p         = pwdata[GAIN_BITS-1:0];
          REG_GAIN_I:         gain_i         = pwdata[GAIN_BITS-1:0];
          REG_GAIN_D:         gain_d         = pwdata[GAIN_BITS-1:0];
          REG_INTEGRAL_LIMIT: integral_limit = pwdata[LIM_BITS-1:0];
          REG_OUTPUT_LIMIT:   output_limit   = pwdata[LIM_BITS-1:0];
          REG_RATE_LIMIT:     rate_limit     = pwdata[LIM_BITS-1:0];
          REG_DEADBAND:       deadband       = pwdata[LIM_BITS-1:0];
          REG_INTEGRAL_BAND:  integral_band  = pwdata[LIM_BITS-1:0];
          default: ;
        endcase
      end
      // Results are checked before the new request is queued, so that a stray result
      // can never consume the expectation of a request accepted on the same edge.
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          note_mismatch("result with no request pending, drive_level", 0, drive_level_o);
        end else begin
          want = expected_results.pop_front();
          if (heater_on_o !== want.heater_on)
            note_mismatch("heater_on", want.heater_on, heater_on_o);
          if (drive_level_o !== want.drive_level)
            note_mismatch("drive_level", want.drive_level, drive_level_o);
          if (pid_level_o !== want.pid_level)
            note_mismatch("pid_level", want.pid_level, pid_level_o);
          if (temp_error_o !== want.temp_error)
            note_mismatch("temp_error", want.temp_error, temp_error_o);
        end
      end
      if (in_valid_i && in_ready_o)
        expected_results.push_back(
          predict_heater_step(target_temp_i, measured_temp_i, feed_forward_i));
    end
    errors_o  <= mismatch_count;
    pending_o <= expected_results.size();
  end

endmodule

// ----- test/tb_pid_heater_control_top.sv -----
`timescale 1ns / 1ps
// Testbench top for pid_heater_control_top: reset, APB register programming, sample
// requests and the result-side back-pressure, plus the final verdict.
// Depends on phc_pkg and on phc_checker, which predicts and compares every result.
module tb_pid_heater_control_top;
  import phc_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int PHASE_COUNT     = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Sample channel, driven by the stimulus process below.
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [DATA_WIDTH-1:0] target_temp   = '0;
  logic signed [DATA_WIDTH-1:0] measured_temp = '0;
  logic signed [DATA_WIDTH-1:0] feed_forward  = '0;

  // Result channel; the ready is randomized by its own process.
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         heater_on;
  logic signed [DATA_WIDTH-1:0] drive_level;
  logic signed [DATA_WIDTH-1:0] pid_level;
  logic signed [ERR_W-1:0]      temp_error;

  // APB configuration port.
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int error_count;
  int pending_count;
  int cycle_count = 0;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // The bands as currently programmed, so that errors can be aimed right at them.
  int cfg_deadband      = DEADBAND_RST;
  int cfg_integral_band = INTEGRAL_BAND_RST;

  always #5 clk_i = ~clk_i;

  pid_heater_control_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .target_temp_i   (target_temp),
    .measured_temp_i (measured_temp),
    .feed_forward_i  (feed_forward),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .heater_on_o     (heater_on),
    .drive_level_o   (drive_level),
    .pid_level_o     (pid_level),
    .temp_error_o    (temp_error),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  phc_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .target_temp_i   (target_temp),
    .measured_temp_i (measured_temp),
    .feed_forward_i  (feed_forward),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .heater_on_o     (heater_on),
    .drive_level_o   (drive_level),
    .pid_level_o     (pid_level),
    .temp_error_o    (temp_error),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .errors_o        (error_count),
    .pending_o       (pending_count)
  );

  // The result side stalls cycle by cycle at the rate the current phase asks for.
  // A stall rate of zero gives long stretches where every result is taken at once.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one sample request and returns at the edge that accepts it. A gap, if the
  // phase calls for one, lowers valid first; otherwise valid stays high from the
  // previous request, so it is never dropped and raised within one time step.
  task automatic send_sample(input logic signed [DATA_WIDTH-1:0] tgt,
                             input logic signed [DATA_WIDTH-1:0] meas,
                             input logic signed [DATA_WIDTH-1:0] ff);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    target_temp   <= tgt;
    measured_temp <= meas;
    feed_forward  <= ff;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Setup and access cycle of one APB write. psel stays high afterwards so that writes
  // can follow back to back; the caller closes the transfer after the last one.
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  // Lowers the sample valid and waits until every expected result has come back, then
  // lets the two-stage pipeline settle.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Programs all eight registers for one phase. Phases cover plausible tunings, all
  // registers at their maximum, zero limits with full gains (the drive then sits outside
  // the new output limit and may not move at all), zero gains, the reset values and fully
  // random settings. The unused upper bits of every write carry random garbage.
  task automatic program_settings(input int phase);
    logic [REG_IDX_W-1:0] r;
    logic [PDATA_W-1:0]   word;
    int                   v;
    bit                   is_gain;
    for (int k = 0; k < REG_COUNT; k++) begin
      r       = REG_IDX_W'(k);
      is_gain = (r == REG_GAIN_P) || (r == REG_GAIN_I) || (r == REG_GAIN_D);
      case (phase)
        1: v = is_gain ? 65535 : 32767;
        2: v = is_gain ? 65535 : 0;
        3, 7: v = $urandom_range(0, is_gain ? 65535 : 32767);
        4: v = is_gain ? 0 : 32767;
        6: begin
          case (r)
            REG_GAIN_P:         v = GAIN_P_RST;
            REG_GAIN_I:         v = GAIN_I_RST;
            REG_GAIN_D:         v = GAIN_D_RST;
            REG_INTEGRAL_LIMIT: v = INTEGRAL_LIMIT_RST;
            REG_OUTPUT_LIMIT:   v = OUTPUT_LIMIT_RST;
            REG_RATE_LIMIT:     v = RATE_LIMIT_RST;
            REG_DEADBAND:       v = DEADBAND_RST;
            default:            v = INTEGRAL_BAND_RST;
          endcase
        end
        default: begin
          case (r)
            REG_INTEGRAL_LIMIT: v = $urandom_range(0, 8192);
            REG_OUTPUT_LIMIT:   v = $urandom_range(0, 16384);
            REG_RATE_LIMIT:     v = $urandom_range(0, 2048);
            REG_DEADBAND:       v = $urandom_range(0, 512);
            REG_INTEGRAL_BAND:  v = $urandom_range(0, 256);
            default:            v = $urandom_range(0, 2048);
          endcase
        end
      endcase
      word = $urandom();
      if (is_gain) word[GAIN_BITS-1:0] = GAIN_BITS'(v);
      else         word[LIM_BITS-1:0]  = LIM_BITS'(v);
      if (r == REG_DEADBAND)      cfg_deadband      = v;
      if (r == REG_INTEGRAL_BAND) cfg_integral_band = v;
      apb_write(r, word);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int setpoint, sensor, tgt, meas, ff, err, pick;
    setpoint = 6400;
    sensor   = 4400;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset settings: extreme fields, errors exactly at and
    // next to both bands, a run of large errors that winds the integral up against its
    // limit while the drive ramps at the rate limit, and the integral clearing again.
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd32767, -16'sd32768, 16'sd0);
    send_sample(-16'sd32768, 16'sd32767, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd32767);
    send_sample(16'sd0, 16'sd0, -16'sd32768);
    send_sample(16'sd26, 16'sd0, 16'sd0);
    send_sample(16'sd27, 16'sd0, 16'sd0);
    send_sample(-16'sd27, 16'sd0, 16'sd0);
    send_sample(16'sd128, 16'sd0, 16'sd0);
    send_sample(16'sd127, 16'sd0, 16'sd0);
    send_sample(-16'sd128, 16'sd0, 16'sd0);
    repeat (6) send_sample(16'sd10000, 16'sd5000, 16'sd0);
    send_sample(16'sd5000, 16'sd5000, 16'sd0);
    send_sample(-16'sd32768, -16'sd32768, -16'sd1);
    send_sample(16'sd32767, 16'sd32767, 16'sd1);
    send_sample(-16'sd1, 16'sd0, -16'sd1);
    drain_pipeline();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      program_settings(phase);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Half the requests follow a sensor that creeps toward a setpoint, which gives
        // the long same-sign error runs that wind the integral up; a fifth aim right at
        // the deadband or the integral band; the rest are random over the whole range.
        if (n % 40 == 0) setpoint = $urandom_range(0, 12800);
        pick = $urandom_range(99);
        if (pick < 50) begin
          sensor = sensor + int'($urandom_range(0, 128)) - 64 + ((setpoint > sensor) ? 24 : -24);
          tgt  = setpoint;
          meas = sensor;
          ff   = int'($urandom_range(0, 1600)) - 800;
        end else if (pick < 70) begin
          err = ($urandom_range(1) ? cfg_deadband : cfg_integral_band)
                + int'($urandom_range(0, 4)) - 2;
          if ($urandom_range(1)) err = -err;
          tgt  = err / 2 + int'($urandom_range(0, 200)) - 100;
          meas = tgt - err;
          ff   = int'($urandom_range(0, 400)) - 200;
        end else begin
          tgt  = $urandom();
          meas = $urandom();
          ff   = $urandom();
        end
        send_sample(DATA_WIDTH'(tgt), DATA_WIDTH'(meas), DATA_WIDTH'(ff));
      end
      drain_pipeline();
    end

    // Anything the controller still hands out now is flagged by the checker as a result
    // without a request; a leftover expectation shows up in the pending count.
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/phc_pkg.sv
hdl/pid_heater_control_top.sv
test/phc_checker.sv
test/tb_pid_heater_control_top.sv
